[rtl/sem_pkg.sv]
package sem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W  = 8;
    localparam int COL_W  = 10;
    localparam int ROW_W  = 12;
    localparam int FW_W   = 11;
    localparam int FH_W   = 13;
    localparam int CFG_W  = 13;
    localparam int CIDX_W = 1;

    localparam logic [FW_W-1:0] FW_MIN   = FW_W'(3);
    localparam logic [FW_W-1:0] FW_MAX   = FW_W'(MAX_WIDTH);
    localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
    localparam logic [FH_W-1:0] FH_MIN   = FH_W'(3);
    localparam logic [FH_W-1:0] FH_MAX   = FH_W'(MAX_HEIGHT);
    localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);

    localparam logic [PIX_W-1:0] CLIP_LEVEL = PIX_W'(255);

    typedef enum logic [CIDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    // the eight pixels of a 3x3 neighbourhood that the kernels use
    typedef struct packed {
        logic [PIX_W-1:0] lt;
        logic [PIX_W-1:0] lm;
        logic [PIX_W-1:0] lb;
        logic [PIX_W-1:0] mt;
        logic [PIX_W-1:0] mb;
        logic [PIX_W-1:0] rt;
        logic [PIX_W-1:0] rm;
        logic [PIX_W-1:0] rb;
    } nbhd_t;

endpackage

[rtl/sem_ram.sv]
module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/sem_kernel.sv]
module sem_kernel (
    input  sem_pkg::nbhd_t              nbhd,
    output logic [sem_pkg::PIX_W-1:0]   magnitude
);

    import sem_pkg::*;

    logic [PIX_W+1:0] x_pos;
    logic [PIX_W+1:0] x_neg;
    logic [PIX_W+1:0] y_pos;
    logic [PIX_W+1:0] y_neg;
    logic [PIX_W+2:0] gx;
    logic [PIX_W+2:0] gy;
    logic [PIX_W+2:0] gx_neg;
    logic [PIX_W+2:0] gy_neg;
    logic [PIX_W+1:0] ax;
    logic [PIX_W+1:0] ay;
    logic [PIX_W+2:0] total;

    always_comb
    begin
        x_pos  = {2'b00, nbhd.rt} + {1'b0, nbhd.rm, 1'b0} + {2'b00, nbhd.rb};
        x_neg  = {2'b00, nbhd.lt} + {1'b0, nbhd.lm, 1'b0} + {2'b00, nbhd.lb};
        y_pos  = {2'b00, nbhd.lb} + {1'b0, nbhd.mb, 1'b0} + {2'b00, nbhd.rb};
        y_neg  = {2'b00, nbhd.lt} + {1'b0, nbhd.mt, 1'b0} + {2'b00, nbhd.rt};
        // two's complement differences, top bit is the sign
        gx     = {1'b0, x_pos} - {1'b0, x_neg};
        gy     = {1'b0, y_pos} - {1'b0, y_neg};
        gx_neg = -gx;
        gy_neg = -gy;
        ax     = gx[PIX_W+2] ? gx_neg[PIX_W+1:0] : gx[PIX_W+1:0];
        ay     = gy[PIX_W+2] ? gy_neg[PIX_W+1:0] : gy[PIX_W+1:0];
        total  = {1'b0, ax} + {1'b0, ay};
        if (total > {3'b000, CLIP_LEVEL})
        begin
            magnitude = CLIP_LEVEL;
        end
        else
        begin
            magnitude = total[PIX_W-1:0];
        end
    end

endmodule

[rtl/sobel_edge_magnitude.sv]
// two stages, stage 1 and the result register; a result is registered as its completing
// pixel leaves stage 1; throughput: one pixel per clock while out_stall is low; the line stores
// are read the cycle a pixel is accepted and their registered data meets the pixel in stage 1
// reset: counters, window and valid flags clear, frame size returns to 640 x 480;
// the line stores are not cleared and need no clearing pass
module sobel_edge_magnitude (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [sem_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [sem_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [sem_pkg::PIX_W-1:0]     pixel,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sem_pkg::PIX_W-1:0]     magnitude,
    output logic [sem_pkg::ROW_W-1:0]     out_row,
    output logic [sem_pkg::COL_W-1:0]     out_col,
    output logic                          frame_last
);

    import sem_pkg::*;

    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    logic [FW_W-1:0]  eff_w;
    logic [FH_W-1:0]  eff_h;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [PIX_W-1:0] s1_pixel_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;

    logic [PIX_W-1:0] win_reg [6];

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [PIX_W-1:0] mag_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic [COL_W-1:0] out_col_reg;
    logic             last_reg;

    logic             accept;
    logic             s1_go;
    logic             emit;
    logic             s1_last;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] mag;
    nbhd_t            nbhd;

    // saturate the frame size into its legal range
    always_comb
    begin
        priority if (width_reg < FW_MIN)
        begin
            eff_w = FW_MIN;
        end
        else if (width_reg > FW_MAX)
        begin
            eff_w = FW_MAX;
        end
        else
        begin
            eff_w = width_reg;
        end
        priority if (height_reg < FH_MIN)
        begin
            eff_h = FH_MIN;
        end
        else if (height_reg > FH_MAX)
        begin
            eff_h = FH_MAX;
        end
        else
        begin
            eff_h = height_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= FW_RESET;
            height_reg <= FH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_FRAME_WIDTH:  width_reg  <= cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: height_reg <= cfg_data[FH_W-1:0];
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    // handshake: stage 1 moves on whenever the result register can take it
    assign s1_go    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_go;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        s1_valid_next = s1_valid_reg;
        if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
            if (({1'b0, col_reg} + FW_W'(1)) >= eff_w)
            begin
                col_next = '0;
                if (({1'b0, row_reg} + FH_W'(1)) >= eff_h)
                begin
                    row_next = '0;
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pixel;
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
        end
    end

    // line stores: read at the accepted column, rows roll down as the item leaves stage 1
    sem_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_older_ram (
        .clk     (clk),
        .wr_en   (s1_go),
        .wr_addr (s1_col_reg),
        .wr_data (mid),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (top)
    );

    sem_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_newer_ram (
        .clk     (clk),
        .wr_en   (s1_go),
        .wr_addr (s1_col_reg),
        .wr_data (s1_pixel_reg),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (mid)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_go)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= s1_pixel_reg;
        end
    end

    always_comb
    begin
        nbhd.lt = win_reg[0];
        nbhd.lm = win_reg[1];
        nbhd.lb = win_reg[2];
        nbhd.mt = win_reg[3];
        nbhd.mb = win_reg[5];
        nbhd.rt = top;
        nbhd.rm = mid;
        nbhd.rb = s1_pixel_reg;
    end

    sem_kernel u_kernel (
        .nbhd      (nbhd),
        .magnitude (mag)
    );

    // interior positions only, reported one row up and one column left
    assign emit    = (s1_row_reg >= ROW_W'(2)) && (s1_col_reg >= COL_W'(2))
                     && ({1'b0, s1_row_reg} < eff_h) && ({1'b0, s1_col_reg} < eff_w);
    assign s1_last = ({1'b0, s1_row_reg} == (eff_h - FH_W'(1)))
                     && ({1'b0, s1_col_reg} == (eff_w - FW_W'(1)));

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_go)
        begin
            out_valid_next = emit;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && emit)
        begin
            mag_reg     <= mag;
            out_row_reg <= s1_row_reg - ROW_W'(1);
            out_col_reg <= s1_col_reg - COL_W'(1);
            last_reg    <= s1_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign magnitude  = mag_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign frame_last = last_reg;

endmodule

[dv/sobel_edge_magnitude_tb.sv]
`timescale 1ns / 100ps

module sobel_edge_magnitude_tb;

    import sem_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 5;
    localparam int DRAIN_CYCLES = 8;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int ITEM_TARGET  = 900;

    typedef struct packed {
        logic [PIX_W-1:0] mag;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } edge_result_t;

    // tracks line stores, window and counters, and queues the magnitudes still owed
    class edge_tracker;
        logic [PIX_W-1:0] older_line [MAX_WIDTH];
        logic [PIX_W-1:0] newer_line [MAX_WIDTH];
        logic [PIX_W-1:0] win [6];
        int unsigned      col_count;
        int unsigned      row_count;
        logic [FW_W-1:0]  width_reg;
        logic [FH_W-1:0]  height_reg;
        edge_result_t     awaited_edges [$];
        int unsigned      mismatches;

        function new();
            foreach (older_line[i])
            begin
                older_line[i] = '0;
                newer_line[i] = '0;
            end
            foreach (win[i])
                win[i] = '0;
            col_count  = 0;
            row_count  = 0;
            width_reg  = FW_RESET;
            height_reg = FH_RESET;
            mismatches = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_FRAME_WIDTH:  width_reg  = value[FW_W-1:0];
                CFG_FRAME_HEIGHT: height_reg = value[FH_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_pixel(logic [PIX_W-1:0] bot);
            int unsigned      w;
            int unsigned      h;
            int unsigned      c;
            int unsigned      r;
            logic [PIX_W-1:0] top;
            logic [PIX_W-1:0] mid;
            int               lt, lm, lb, mt, mb, rt, rm, rb;
            int               gx, gy, sum;
            edge_result_t     res;

            w = width_reg;
            if (w < FW_MIN) w = FW_MIN;
            if (w > FW_MAX) w = FW_MAX;
            h = height_reg;
            if (h < FH_MIN) h = FH_MIN;
            if (h > FH_MAX) h = FH_MAX;
            c = col_count;
            r = row_count;

            top = '0;
            mid = '0;
            if (c < MAX_WIDTH)
            begin
                top = older_line[c];
                mid = newer_line[c];
                older_line[c] = mid;
                newer_line[c] = bot;
            end

            if (r >= 2 && c >= 2 && r < h && c < w)
            begin
                lt = win[0];
                lm = win[1];
                lb = win[2];
                mt = win[3];
                mb = win[5];
                rt = top;
                rm = mid;
                rb = bot;
                gx = (rt + 2 * rm + rb) - (lt + 2 * lm + lb);
                gy = (lb + 2 * mb + rb) - (lt + 2 * mt + rt);
                sum = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
                if (sum > int'(CLIP_LEVEL))
                    sum = int'(CLIP_LEVEL);
                res.mag  = PIX_W'(sum);
                res.row  = ROW_W'(r - 1);
                res.col  = COL_W'(c - 1);
                res.last = (r == h - 1) && (c == w - 1);
                awaited_edges.push_back(res);
            end

            win[0] = win[3];
            win[1] = win[4];
            win[2] = win[5];
            win[3] = top;
            win[4] = mid;
            win[5] = bot;

            // a counter left past a shrunken size closes the row on this pixel
            if (c + 1 >= w)
            begin
                col_count = 0;
                row_count = (r + 1 >= h) ? 0 : r + 1;
            end
            else
                col_count = c + 1;
        endfunction

        function void check_edge(logic [PIX_W-1:0] mag, logic [ROW_W-1:0] row,
                                 logic [COL_W-1:0] col, logic last);
            edge_result_t want;

            if (awaited_edges.size() == 0)
            begin
                mismatches++;
                $display("%0t: result expected none actual mag %0d row %0d col %0d last %0b",
                         $time, mag, row, col, last);
                return;
            end
            want = awaited_edges.pop_front();
            if (mag !== want.mag)
            begin
                mismatches++;
                $display("%0t: magnitude expected %0d actual %0d", $time, want.mag, mag);
            end
            if (row !== want.row)
            begin
                mismatches++;
                $display("%0t: out_row expected %0d actual %0d", $time, want.row, row);
            end
            if (col !== want.col)
            begin
                mismatches++;
                $display("%0t: out_col expected %0d actual %0d", $time, want.col, col);
            end
            if (last !== want.last)
            begin
                mismatches++;
                $display("%0t: frame_last expected %0b actual %0b", $time, want.last, last);
            end
        endfunction
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_write = 1'b0;
    cfg_index_t       cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    logic [PIX_W-1:0] pixel     = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [PIX_W-1:0] magnitude;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             frame_last;

    edge_tracker tracker;
    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct  = 0;
    int unsigned hold_request    = 0;
    int unsigned hold_left       = 0;
    int unsigned quiet_cycles    = 0;
    int unsigned items_sent      = 0;

    sobel_edge_magnitude dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel      (pixel),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .magnitude  (magnitude),
        .out_row    (out_row),
        .out_col    (out_col),
        .frame_last (frame_last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            tracker.note_pixel(pixel);
        if (rst_n && out_valid && !out_stall)
            tracker.check_edge(magnitude, out_row, out_col, frame_last);
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic set_idling(input int unsigned phase);
        case (phase % 4)
            0:
            begin
                sender_idle_pct = 0;
                recv_stall_pct  = 0;
            end
            1:
            begin
                sender_idle_pct = 57;
                recv_stall_pct  = 0;
            end
            2:
            begin
                sender_idle_pct = 0;
                recv_stall_pct  = 57;
            end
            default:
            begin
                sender_idle_pct = 11;
                recv_stall_pct  = 11;
            end
        endcase
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] value);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // extremes are weighted up so clipping and flat areas turn up often
    task automatic send_random(input int unsigned count);
        logic [PIX_W-1:0] value;

        repeat (count)
        begin
            case ($urandom_range(3))
                0:       value = '0;
                1:       value = '1;
                default: value = PIX_W'($urandom_range(255));
            endcase
            send_pixel(value);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.awaited_edges.size() != 0)
            @(posedge clk);
        // border pixels leave nothing behind to wait for
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_one(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        tracker.write_reg(idx, value);
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] width_val,
                             input logic [CFG_W-1:0] height_val);
        cfg_write <= 1'b1;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data  <= width_val;
        @(posedge clk);
        cfg_index <= CFG_FRAME_HEIGHT;
        cfg_data  <= height_val;
        @(posedge clk);
        cfg_write <= 1'b0;
        tracker.write_reg(CFG_FRAME_WIDTH, width_val);
        tracker.write_reg(CFG_FRAME_HEIGHT, height_val);
    endtask

    initial
    begin
        logic [PIX_W-1:0] step_frame [9];
        int unsigned      phase;
        int unsigned      w;
        int unsigned      h;
        int unsigned      n;

        tracker = new();
        phase = 0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset height kept: four rows pass with no frame end, then cut the frame to five rows
        set_idling(phase++);
        write_one(CFG_FRAME_WIDTH, CFG_W'(3));
        send_random(4 * 3);
        wait_drained();
        write_one(CFG_FRAME_HEIGHT, CFG_W'(5));
        send_random(3);
        wait_drained();

        // vertical step clips to full scale, flat bright frame gives zero
        set_idling(phase++);
        set_frame(CFG_W'(3), CFG_W'(3));
        step_frame = '{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255};
        foreach (step_frame[i])
            send_pixel(step_frame[i]);
        repeat (9)
            send_pixel(8'd255);
        wait_drained();

        // sizes below range saturate to 3 x 3
        set_idling(phase++);
        set_frame(CFG_W'(0), CFG_W'(2));
        send_random(27);
        wait_drained();

        // width shrunk onto the column counter mid-frame
        set_idling(phase++);
        set_frame(CFG_W'(10), CFG_W'(6));
        send_random(27);
        wait_drained();
        write_one(CFG_FRAME_WIDTH, CFG_W'(7));
        send_random(1 + 3 * 7);
        wait_drained();

        // height shrunk below the row counter mid-frame
        set_idling(phase++);
        set_frame(CFG_W'(5), CFG_W'(8));
        send_random(25);
        wait_drained();
        write_one(CFG_FRAME_HEIGHT, CFG_W'(4));
        send_random(5);
        wait_drained();

        // long receiver hold-off while pixels keep coming
        set_idling(0);
        set_frame(CFG_W'(8), CFG_W'(6));
        hold_request = HOLD_CYCLES;
        send_random(8 * 6 * 2);
        wait_drained();

        while (items_sent < ITEM_TARGET)
        begin
            set_idling(phase++);
            w = ($urandom_range(3) == 0) ? $urandom_range(3, 24) : $urandom_range(3, 12);
            h = $urandom_range(3, 6);
            n = w * h * $urandom_range(1, 2);
            set_frame(CFG_W'(w), CFG_W'(h));
            send_random(n);
            wait_drained();
        end

        if (tracker.mismatches == 0 && tracker.awaited_edges.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
